[hw/rtl/lpdc_pkg.sv]
package lpdc_pkg;

  // Default configuration
  localparam int DEF_LINE_LIMIT  = 511;
  localparam int DEF_COUNT_WIDTH = 16;

  // Width of each reported count field
  localparam int OUT_W = 16;

  // Bytes of history kept behind the current byte
  localparam int HIST_BYTES = 19;

  // Line end characters
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  // Patterns, first character in the most significant byte
  localparam int LUKS_LEN  = 20;
  localparam int CRYPT_LEN = 12;
  localparam int SWAP_LEN  = 13;

  localparam logic [8*LUKS_LEN-1:0]  PAT_LUKS  = {"FSTYPE=\"crypto", "_LUKS\""};
  localparam logic [8*CRYPT_LEN-1:0] PAT_CRYPT = "TYPE=\"crypt\"";
  localparam logic [8*SWAP_LEN-1:0]  PAT_SWAP  = "FSTYPE=\"swap\"";

  // Per-line match flags
  typedef struct packed {
    logic swap;
    logic crypt;
    logic luks;
  } lpdc_flags_t;

  // Matcher to counter: what this item does to the line
  typedef struct packed {
    logic        clear;   // first item of a text
    logic        eol;     // item ends the line
    lpdc_flags_t commit;  // flags of the line being closed
    lpdc_flags_t live;    // flags of the line after this item
  } lpdc_line_t;

  // One result item
  typedef struct packed {
    logic [OUT_W-1:0] encrypted_volume_count;
    logic [OUT_W-1:0] crypt_device_count;
    logic [OUT_W-1:0] encrypted_swap_count;
  } lpdc_result_t;

endpackage

[hw/rtl/lpdc_matcher.sv]
module lpdc_matcher #(
  parameter int LINE_LIMIT = lpdc_pkg::DEF_LINE_LIMIT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                first_of_text,
  output lpdc_pkg::lpdc_line_t line_info
);
  import lpdc_pkg::*;

  localparam int POS_W = $clog2(LINE_LIMIT + 1);
  localparam int WIN_W = 8 * (HIST_BYTES + 1);

  logic [8*HIST_BYTES-1:0] hist;
  logic [8*HIST_BYTES-1:0] hist_eff;
  logic [8*HIST_BYTES-1:0] hist_next;
  logic [POS_W-1:0]        pos;
  logic [POS_W-1:0]        pos_eff;
  logic [POS_W-1:0]        pos_next;
  lpdc_flags_t             flags;
  lpdc_flags_t             flags_eff;
  lpdc_flags_t             flags_next;
  lpdc_flags_t             hit;
  logic [WIN_W-1:0]        window;
  logic                    eol;
  logic                    in_range;

  // Window compare and line tracking
  always_comb begin
    hist_eff  = first_of_text ? '0 : hist;
    pos_eff   = first_of_text ? '0 : pos;
    flags_eff = first_of_text ? '0 : flags;
    window    = {hist_eff, text_byte};
    eol       = (text_byte == CHAR_CR) || (text_byte == CHAR_LF);
    in_range  = pos_eff < POS_W'(LINE_LIMIT);

    // a match needs as many bytes of this line as the pattern is long
    hit.luks  = in_range && (pos_eff >= POS_W'(LUKS_LEN - 1)) &&
                (window[8*LUKS_LEN-1:0] == PAT_LUKS);
    hit.crypt = in_range && (pos_eff >= POS_W'(CRYPT_LEN - 1)) &&
                (window[8*CRYPT_LEN-1:0] == PAT_CRYPT);
    hit.swap  = in_range && (pos_eff >= POS_W'(SWAP_LEN - 1)) &&
                (window[8*SWAP_LEN-1:0] == PAT_SWAP);

    if (eol) begin
      flags_next = '0;
      pos_next   = '0;
    end else begin
      flags_next = flags_eff | hit;
      pos_next   = in_range ? pos_eff + 1'b1 : pos_eff;
    end

    hist_next = {hist_eff[8*(HIST_BYTES-1)-1:0], text_byte};

    line_info.clear  = first_of_text;
    line_info.eol    = eol;
    line_info.commit = flags_eff;
    line_info.live   = flags_next;
  end

  // Line state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist  <= '0;
      pos   <= '0;
      flags <= '0;
    end else if (accept) begin
      hist  <= hist_next;
      pos   <= pos_next;
      flags <= flags_next;
    end
  end

endmodule

[hw/rtl/lpdc_counter.sv]
module lpdc_counter #(
  parameter int COUNT_WIDTH = lpdc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  lpdc_pkg::lpdc_line_t  line_info,
  output lpdc_pkg::lpdc_result_t result
);
  import lpdc_pkg::*;

  logic [COUNT_WIDTH-1:0] luks_cnt;
  logic [COUNT_WIDTH-1:0] crypt_cnt;
  logic [COUNT_WIDTH-1:0] swap_cnt;
  logic [COUNT_WIDTH-1:0] luks_base;
  logic [COUNT_WIDTH-1:0] crypt_base;
  logic [COUNT_WIDTH-1:0] swap_base;
  logic [COUNT_WIDTH-1:0] luks_next;
  logic [COUNT_WIDTH-1:0] crypt_next;
  logic [COUNT_WIDTH-1:0] swap_next;
  logic                   commit_both;
  logic                   live_both;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v,
                                                      input logic inc);
    return (inc && (v != '1)) ? v + 1'b1 : v;
  endfunction

  // Commit on line end, then add the live line's flags for the report
  always_comb begin
    commit_both = line_info.commit.crypt && line_info.commit.swap;
    live_both   = line_info.live.crypt && line_info.live.swap;

    luks_base  = line_info.clear ? '0 : luks_cnt;
    crypt_base = line_info.clear ? '0 : crypt_cnt;
    swap_base  = line_info.clear ? '0 : swap_cnt;

    if (line_info.eol) begin
      luks_next  = sat_inc(luks_base, line_info.commit.luks);
      crypt_next = sat_inc(crypt_base, line_info.commit.crypt);
      swap_next  = sat_inc(swap_base, commit_both);
    end else begin
      luks_next  = luks_base;
      crypt_next = crypt_base;
      swap_next  = swap_base;
    end

    result.encrypted_volume_count = OUT_W'(sat_inc(luks_next, line_info.live.luks));
    result.crypt_device_count     = OUT_W'(sat_inc(crypt_next, line_info.live.crypt));
    result.encrypted_swap_count   = OUT_W'(sat_inc(swap_next, live_both));
  end

  // Committed counts
  always_ff @(posedge clk) begin
    if (rst) begin
      luks_cnt  <= '0;
      crypt_cnt <= '0;
      swap_cnt  <= '0;
    end else if (accept) begin
      luks_cnt  <= luks_next;
      crypt_cnt <= crypt_next;
      swap_cnt  <= swap_next;
    end
  end

endmodule

[hw/rtl/lpdc_out_buf.sv]
module lpdc_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  lpdc_pkg::lpdc_result_t push_data,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lpdc_pkg::lpdc_result_t out_data
);
  import lpdc_pkg::*;

  logic         skid_valid;
  lpdc_result_t skid_data;
  logic         out_free;

  // Output register can take a new item this cycle
  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : push_data;
    end
    if (!out_free && push) begin
      skid_data <= push_data;
    end
  end

endmodule

[hw/rtl/line_pattern_device_counter.sv]
// Line pattern device counter. Takes a text one byte per item; CR or LF ends
// a line. Each line is scanned for the LUKS filesystem pattern, TYPE="crypt"
// and FSTYPE="swap", counting only matches that lie wholly within the first
// LINE_LIMIT characters of the line. Every input item yields one result item
// with the saturating running counts of LUKS lines, crypt lines and lines
// holding both crypt and swap, including the line in progress. Setting
// first_of_text clears all counts and line history before that byte is taken.
// Throughput is one item per clock while in_stall is low; each result is
// registered. A registered output stage with one skid entry lets the block
// take one more item while a result is stalled; in_stall rises only when both
// are occupied. No clearing pass is needed after reset.
module line_pattern_device_counter #(
  parameter int LINE_LIMIT  = lpdc_pkg::DEF_LINE_LIMIT,
  parameter int COUNT_WIDTH = lpdc_pkg::DEF_COUNT_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 text_byte,
  input  logic                       first_of_text,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lpdc_pkg::OUT_W-1:0] encrypted_volume_count,
  output logic [lpdc_pkg::OUT_W-1:0] crypt_device_count,
  output logic [lpdc_pkg::OUT_W-1:0] encrypted_swap_count
);
  import lpdc_pkg::*;

  logic         accept;
  logic         buf_full;
  lpdc_line_t   line_info;
  lpdc_result_t result;
  lpdc_result_t out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  lpdc_matcher #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_matcher (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .text_byte    (text_byte),
    .first_of_text(first_of_text),
    .line_info    (line_info)
  );

  lpdc_counter #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counter (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .line_info(line_info),
    .result   (result)
  );

  lpdc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(result),
    .full     (buf_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign encrypted_volume_count = out_data.encrypted_volume_count;
  assign crypt_device_count     = out_data.crypt_device_count;
  assign encrypted_swap_count   = out_data.encrypted_swap_count;

endmodule

[hw/rtl/lpdc_checker.sv]
module lpdc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       first_of_text,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lpdc_pkg::OUT_W-1:0] encrypted_volume_count,
  input logic [lpdc_pkg::OUT_W-1:0] crypt_device_count,
  input logic [lpdc_pkg::OUT_W-1:0] encrypted_swap_count
);

  // A stalled result holds its counts
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(encrypted_volume_count) &&
      $stable(crypt_device_count) && $stable(encrypted_swap_count)))
    else $error("stalled result changed");

  // Input is held off only while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A taken result frees the skid entry
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall) |=> !in_stall)
    else $error("input still stalled after a result was taken");

  // First item of a text reports all counts at zero
  a_first_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && first_of_text && (!out_valid || !out_stall)) |=>
      (out_valid && (encrypted_volume_count == '0) && (crypt_device_count == '0) &&
       (encrypted_swap_count == '0)))
    else $error("first item of a text did not clear counts");

endmodule

bind line_pattern_device_counter lpdc_checker u_lpdc_checker (
  .clk                   (clk),
  .rst                   (rst),
  .in_valid              (in_valid),
  .in_stall              (in_stall),
  .first_of_text         (first_of_text),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .encrypted_volume_count(encrypted_volume_count),
  .crypt_device_count    (crypt_device_count),
  .encrypted_swap_count  (encrypted_swap_count)
);
